FILE: rtl/npn_pkg.sv
// Shared types, permutation table and helper functions for the NPN canonical form block.
`default_nettype none

package npn_pkg;

  localparam int unsigned TT_W      = 16;
  localparam int unsigned N_W       = 3;
  localparam int unsigned PERM_NUM  = 24;
  localparam int unsigned PIDX_W    = 5;
  localparam int unsigned GROUPS    = 4;

  typedef logic [TT_W-1:0]        tt_t;
  typedef logic [3:0][1:0]        perm_t;
  typedef tt_t  [GROUPS-1:0]      part_t;

  // Ordered so that the first k! entries permute only the low k inputs.
  localparam perm_t PERM_TABLE [PERM_NUM] = '{
    {2'd3, 2'd2, 2'd1, 2'd0}, {2'd3, 2'd2, 2'd0, 2'd1},
    {2'd3, 2'd1, 2'd2, 2'd0}, {2'd3, 2'd0, 2'd2, 2'd1},
    {2'd3, 2'd1, 2'd0, 2'd2}, {2'd3, 2'd0, 2'd1, 2'd2},
    {2'd0, 2'd3, 2'd2, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
    {2'd0, 2'd3, 2'd1, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
    {2'd0, 2'd2, 2'd1, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3},
    {2'd1, 2'd3, 2'd2, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd1, 2'd3, 2'd0, 2'd2}, {2'd1, 2'd0, 2'd3, 2'd2},
    {2'd1, 2'd2, 2'd0, 2'd3}, {2'd1, 2'd0, 2'd2, 2'd3},
    {2'd2, 2'd3, 2'd1, 2'd0}, {2'd2, 2'd1, 2'd3, 2'd0},
    {2'd2, 2'd3, 2'd0, 2'd1}, {2'd2, 2'd0, 2'd3, 2'd1},
    {2'd2, 2'd1, 2'd0, 2'd3}, {2'd2, 2'd0, 2'd1, 2'd3}
  };

  function automatic tt_t full_mask(input logic [N_W-1:0] n);
    tt_t r;
    unique case (n)
      3'd0:    r = 16'h0001;
      3'd1:    r = 16'h0003;
      3'd2:    r = 16'h000f;
      3'd3:    r = 16'h00ff;
      default: r = 16'hffff;
    endcase
    return r;
  endfunction

  function automatic tt_t top_bit(input logic [N_W-1:0] n);
    tt_t r;
    unique case (n)
      3'd0:    r = 16'h0001;
      3'd1:    r = 16'h0002;
      3'd2:    r = 16'h0008;
      3'd3:    r = 16'h0080;
      default: r = 16'h8000;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] neg_mask(input logic [N_W-1:0] n);
    logic [3:0] r;
    unique case (n)
      3'd0:    r = 4'b0000;
      3'd1:    r = 4'b0001;
      3'd2:    r = 4'b0011;
      3'd3:    r = 4'b0111;
      default: r = 4'b1111;
    endcase
    return r;
  endfunction

  function automatic logic [PIDX_W-1:0] perm_count(input logic [N_W-1:0] n);
    logic [PIDX_W-1:0] r;
    unique case (n)
      3'd0:    r = 5'd1;
      3'd1:    r = 5'd1;
      3'd2:    r = 5'd2;
      3'd3:    r = 5'd6;
      default: r = 5'd24;
    endcase
    return r;
  endfunction

  function automatic tt_t tt_min(input tt_t a, input tt_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/npn_eval.sv
// Shared evaluator: one input permutation, all negation masks and polarities, partial minima.
`default_nettype none

module npn_eval (
  input  npn_pkg::tt_t              tt_i,
  input  logic [npn_pkg::N_W-1:0]   n_i,
  input  npn_pkg::perm_t            perm_i,
  output npn_pkg::part_t            part_o
);
  import npn_pkg::*;

  tt_t        cand [16];
  tt_t        full;
  tt_t        top;
  logic [3:0] nmask;
  logic [3:0] src;
  logic [3:0] m_b;
  logic [3:0] g_b;
  tt_t        t;

  assign full  = full_mask(n_i);
  assign top   = top_bit(n_i);
  assign nmask = neg_mask(n_i);

  always_comb begin
    src = '0;
    m_b = '0;
    g_b = '0;
    t   = '0;
    for (int g = 0; g < 16; g++) begin
      g_b = 4'(g);
      for (int m = 0; m < 16; m++) begin
        m_b = 4'(m);
        src = '0;
        for (int i = 0; i < 4; i++) begin
          src[perm_i[i]] = m_b[i] ^ g_b[i];
        end
        t[m] = tt_i[src];
      end
      t = t & full;
      // pick the polarity whose top row is zero
      if ((t & top) != '0) begin
        t = t ^ full;
      end
      if ((g_b & ~nmask) != 4'b0000) begin
        t = '1;
      end
      cand[g] = t;
    end
  end

  always_comb begin
    for (int k = 0; k < GROUPS; k++) begin
      part_o[k] = tt_min(tt_min(cand[4*k], cand[4*k+1]),
                         tt_min(cand[4*k+2], cand[4*k+3]));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/npn_canonical_truth_table.sv
// Top level: NPN canonical form of a truth table of up to four inputs.
//
// Usage: present truth_table_i and num_inputs_i with in_valid_i; the request
// is taken at a rising edge with in_valid_i high and in_stall_o low. Only the
// low 2^n table bits count; n above MAX_INPUTS is clipped to MAX_INPUTS.
// The block tries one input permutation per cycle through a shared evaluator
// that covers all negation masks and both output polarities at once.
// After accept it runs through the permutations of the n inputs (1 for n of 0
// or 1, 2 for n = 2, 6 for n = 3, 24 for n = 4), then the partial minima register,
// the final minimum stage and the output register. One request is in work at a time;
// the next one is taken once the result sits in the output register.
// out_valid_o holds with canonical_table_o stable while out_stall_i is high;
// a finished result waits in the pipeline until the output register frees.
// Reset clears the sequencer and the output valid; no result is pending.
`default_nettype none

module npn_canonical_truth_table #(
  parameter int unsigned MAX_INPUTS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  npn_pkg::tt_t                 truth_table_i,
  input  logic [npn_pkg::N_W-1:0]      num_inputs_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output npn_pkg::tt_t                 canonical_table_o
);
  import npn_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH} state_e;

  state_e              state_q;
  tt_t                 tt_q;
  logic [N_W-1:0]      n_q;
  logic [PIDX_W-1:0]   cnt_q;
  logic [PIDX_W-1:0]   limit_q;
  part_t               part_q;
  logic                v1_q;
  tt_t                 best_q;
  tt_t                 out_q;
  logic                out_valid_q;

  logic [N_W-1:0]      n_eff;
  part_t               part_d;
  tt_t                 best_d;
  logic                in_acc;
  logic                out_load;

  assign n_eff = (num_inputs_i > N_W'(MAX_INPUTS)) ? N_W'(MAX_INPUTS) : num_inputs_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_FLUSH) && !v1_q && (!out_valid_q || !out_stall_i);

  npn_eval u_eval (
    .tt_i   (tt_q),
    .n_i    (n_q),
    .perm_i (PERM_TABLE[cnt_q]),
    .part_o (part_d)
  );

  assign best_d = tt_min(tt_min(tt_min(part_q[0], part_q[1]),
                                tt_min(part_q[2], part_q[3])), best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      limit_q     <= '0;
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= (state_q == S_RUN);
      if (state_q == S_RUN) begin
        part_q <= part_d;
      end
      if (v1_q) begin
        best_q <= best_d;
      end
      if (out_load) begin
        out_q       <= best_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            tt_q    <= truth_table_i & full_mask(n_eff);
            n_q     <= n_eff;
            cnt_q   <= '0;
            limit_q <= perm_count(n_eff);
            best_q  <= '1;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_q <= cnt_q + PIDX_W'(1);
          if (cnt_q == limit_q - PIDX_W'(1)) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign canonical_table_o = out_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (cnt_q < limit_q))
    else $error("permutation index past limit");

  a_stage_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(state_q == S_RUN))
    else $error("stage valid without a run cycle");

  a_best_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FLUSH) && !v1_q) |-> ((best_q & ~full_mask(n_q)) == '0))
    else $error("result wider than table");

  a_accept_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !v1_q)
    else $error("request taken with pipeline busy");

endmodule

`default_nettype wire

FILE: tb/tb_npn_canonical_truth_table.sv
// Testbench for npn_canonical_truth_table: random and directed tables checked against an NPN search.
`default_nettype none

class canon_scoreboard;
  npn_pkg::tt_t expected_canon[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  // Exhaustive NPN search: every input permutation, input negation and output polarity.
  function npn_pkg::tt_t canon_of(npn_pkg::tt_t tt, logic [2:0] n_raw);
    int n;
    int rows;
    int p[4];
    bit ok;
    npn_pkg::tt_t full;
    npn_pkg::tt_t best;
    npn_pkg::tt_t t;
    logic [3:0] src;
    n = (n_raw > 3'd4) ? 4 : int'(n_raw);
    rows = 1 << n;
    full = (n == 4) ? 16'hffff : npn_pkg::tt_t'((32'd1 << rows) - 1);
    tt &= full;
    best = 16'hffff;
    for (int code = 0; code < 256; code++) begin
      ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
        p[i] = (code >> (2 * i)) & 3;
        if (i < n ? (p[i] >= n) : (p[i] != 0)) ok = 1'b0;
      end
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++)
          if (p[i] == p[j]) ok = 1'b0;
      if (!ok) continue;
      for (int neg = 0; neg < rows; neg++) begin
        t = '0;
        for (int m = 0; m < rows; m++) begin
          src = '0;
          for (int i = 0; i < n; i++) src[p[i]] = m[i] ^ neg[i];
          t[m] = tt[src];
        end
        t &= full;
        if (t < best) best = t;
        if ((~t & full) < best) best = ~t & full;
      end
    end
    return best;
  endfunction

  task report(string msg);
    $display("ERROR: %s", msg);
    errors++;
  endtask

  function void note_request(npn_pkg::tt_t tt, logic [2:0] n);
    expected_canon = {expected_canon, canon_of(tt, n)};
  endfunction

  task check_result(npn_pkg::tt_t got);
    npn_pkg::tt_t want;
    if (expected_canon.size() == 0) begin
      report($sformatf("unexpected result canonical_table=%h", got));
    end else begin
      want = expected_canon.pop_front();
      if (got !== want)
        report($sformatf("canonical_table got %h expected %h", got, want));
    end
  endtask
endclass

module tb_npn_canonical_truth_table;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  npn_pkg::tt_t       truth_table_i;
  logic [2:0]         num_inputs_i;
  logic               out_valid_o;
  logic               out_stall_i;
  npn_pkg::tt_t       canonical_table_o;

  canon_scoreboard sb;
  int idle_pct;
  int stall_pct;
  bit hold_active;
  event hold_go;

  npn_canonical_truth_table #(.MAX_INPUTS(4)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .truth_table_i    (truth_table_i),
    .num_inputs_i     (num_inputs_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .canonical_table_o(canonical_table_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // long output hold-off
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_go);
      hold_active = 1'b1;
      repeat (300) @(negedge clk_i);
      hold_active = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(canonical_table_o);
  end

  task send_request(npn_pkg::tt_t tt, logic [2:0] n);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      truth_table_i = npn_pkg::tt_t'($urandom);
      num_inputs_i = 3'($urandom);
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    truth_table_i = tt;
    num_inputs_i = n;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(tt, n);
    @(negedge clk_i);
  endtask

  task wait_all_results();
    in_valid_i = 1'b0;
    while (sb.expected_canon.size() != 0) @(negedge clk_i);
  endtask

  task send_random(int count);
    npn_pkg::tt_t tt;
    logic [2:0] n;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0, 1: tt = npn_pkg::tt_t'($urandom);
        2:    tt = 16'h1 << $urandom_range(15);
        default: tt = ~(16'h1 << $urandom_range(15));
      endcase
      if ($urandom_range(99) < 85) n = 3'($urandom_range(1, 4));
      else n = 3'($urandom_range(0, 7));
      send_request(tt, n);
    end
  endtask

  initial begin
    sb = new();
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    truth_table_i = '0;
    num_inputs_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: table extremes, every input count incl. zero and saturated counts
    for (int n = 0; n < 8; n++) begin
      send_request(16'h0000, 3'(n));
      send_request(16'hffff, 3'(n));
    end
    send_request(16'h8000, 3'd4);
    send_request(16'h0001, 3'd4);
    send_request(16'h6996, 3'd4);
    send_request(16'haaaa, 3'd4);
    send_request(16'h00ff, 3'd3);
    send_request(16'h5a3c, 3'd2);
    send_request(16'hfffe, 3'd1);
    send_request(16'h1234, 3'd0);
    wait_all_results();

    send_random(270);
    idle_pct = 75;
    send_random(270);
    idle_pct = 0;
    stall_pct = 75;
    send_random(270);

    // fill the block while the output is held off
    stall_pct = 0;
    ->hold_go;
    send_random(20);
    wait_all_results();

    idle_pct = 37;
    stall_pct = 37;
    send_random(250);

    wait_all_results();
    repeat (40) @(posedge clk_i);
    if (sb.expected_canon.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_canon.size()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: npn_canonical_truth_table.f
rtl/npn_pkg.sv
rtl/npn_eval.sv
rtl/npn_canonical_truth_table.sv
tb/tb_npn_canonical_truth_table.sv
